// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

   localparam int KIND_W  = 3;
   localparam int ENTRY_W = 8;
   localparam int HITS_W  = 16;
   localparam int CAND_W  = 8;
   localparam int FSIZE_W = 5;
   localparam int APB_W   = 32;
   localparam int PADDR_W = 3;

   localparam logic [FSIZE_W-1:0] FSIZE_RESET = 5'd16;

   // register index taken from paddr[2]
   localparam logic REG_FRAME_SIZE = 1'b0;

   localparam logic [KIND_W-1:0] KIND_HIT       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_FREE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INS_EVICT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RD_ENTRY  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RD_EMPTY  = 3'd4;

   localparam logic MODE_RECOMMEND = 1'b0;
   localparam logic MODE_READOUT   = 1'b1;

endpackage

// ===== rtl/lfu_req_if.sv =====
`timescale 1ns / 1ps

interface lfu_req_if;
   import lfu_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [CAND_W-1:0] candidate;

   modport source (output valid, mode, candidate, input ready);
   modport sink   (input valid, mode, candidate, output ready);
endinterface

// ===== rtl/lfu_rsp_if.sv =====
`timescale 1ns / 1ps

interface lfu_rsp_if;
   import lfu_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [ENTRY_W-1:0] entry_id;
   logic [HITS_W-1:0]  hit_count;
   logic [ENTRY_W-1:0] evicted_id;
   logic               last;

   modport source (output valid, kind, entry_id, hit_count, evicted_id, last, input ready);
   modport sink   (input valid, kind, entry_id, hit_count, evicted_id, last, output ready);
endinterface

// ===== rtl/lfu_frame_replacement_unit.sv =====
`timescale 1ns / 1ps

// LFU frame replacement unit. Holds up to SLOTS (identifier, hit count) slots in
// insertion order in a slot RAM with one write port and one registered read port,
// walked by one compare unit under a small sequencer; the unit takes one request
// at a time.
// A recommend request makes one compare pass over the held slots; on a hit or a
// free insert it then writes one slot, and when it evicts (lowest count, oldest on
// ties) the slots above the victim are shifted down one per cycle and the new slot
// is written at the end.
// A readout request makes one pass over the RAM per identifier returned, in
// ascending order; an empty frame returns a single empty marker. The result
// register lets a new request be taken while the last result still waits. The
// user must write frame_size over the APB-style port only while the unit is idle;
// the unit does not enforce this. 0 acts as 1 and values above SLOTS act as SLOTS.
module lfu_frame_replacement_unit #(
   parameter int SLOTS      = 16,
   parameter int ID_BITS    = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   lfu_req_if.sink                      req_chan,
   lfu_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lfu_pkg::PADDR_W-1:0]  paddr,
   input  logic [lfu_pkg::APB_W-1:0]    pwdata,
   output logic [lfu_pkg::APB_W-1:0]    prdata,
   output logic                         pready
);
   import lfu_pkg::*;

   localparam int OCC_W = $clog2(SLOTS + 1);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MW    = ID_BITS + COUNT_BITS;
   localparam int CW    = OCC_W + FSIZE_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;
   localparam logic [2:0] S_PUT    = 3'd5;
   localparam logic [2:0] S_RSCAN  = 3'd6;

   localparam logic [OCC_W-1:0]      OCC_ONE   = OCC_W'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [MW-1:0] slot_mem [SLOTS];

   logic [2:0]            state_ff, state_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [FSIZE_W-1:0]    fsize_ff, fsize_in;
   logic [OCC_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [OCC_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [MW-1:0]         rd_data_ff;
   logic [ID_BITS-1:0]    cand_ff, cand_in;
   logic                  hit_ff, hit_in;
   logic [OCC_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0] hit_val_ff, hit_val_in;
   logic                  sel_ok_ff, sel_ok_in;
   logic [OCC_W-1:0]      sel_idx_ff, sel_idx_in;
   logic [ID_BITS-1:0]    sel_id_ff, sel_id_in;
   logic [COUNT_BITS-1:0] sel_val_ff, sel_val_in;
   logic                  have_prev_ff, have_prev_in;
   logic [ID_BITS-1:0]    prev_id_ff, prev_id_in;
   logic [OCC_W-1:0]      emit_cnt_ff, emit_cnt_in;
   logic [KIND_W-1:0]     res_kind_ff, res_kind_in;
   logic [ID_BITS-1:0]    res_id_ff, res_id_in;
   logic [COUNT_BITS-1:0] res_hits_ff, res_hits_in;
   logic [ID_BITS-1:0]    res_ev_ff, res_ev_in;
   logic                  res_last_ff, res_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [ENTRY_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [HITS_W-1:0]     rsp_hits_ff, rsp_hits_in;
   logic [ENTRY_W-1:0]    rsp_ev_ff, rsp_ev_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   logic [MW-1:0]         mem_wd;
   logic [IDX_W-1:0]      mem_ra;

   logic [ID_BITS-1:0]    d_id;
   logic [COUNT_BITS-1:0] d_hits;
   logic [OCC_W-1:0]      occ_m1;
   logic                  last_rd;
   logic                  issue;
   logic                  take_min;
   logic                  take_asc;
   logic                  frame_full;
   logic [CW-1:0]         eff_size;
   logic                  req_fire;
   logic                  out_free;
   logic                  csr_wr;
   logic [CAND_W+ID_BITS-1:0]  cand_ext;
   logic [ID_BITS+ENTRY_W-1:0] id_ext;
   logic [ID_BITS+ENTRY_W-1:0] ev_ext;
   logic [COUNT_BITS+HITS_W-1:0] hits_ext;
   logic [COUNT_BITS-1:0] hit_sat;

   assign d_id    = rd_data_ff[MW-1:COUNT_BITS];
   assign d_hits  = rd_data_ff[COUNT_BITS-1:0];
   assign occ_m1  = occ_ff - OCC_ONE;
   assign last_rd = rd_vld_ff && (rd_idx_ff == occ_m1);
   assign issue   = (state_ff == S_SCAN || state_ff == S_SHIFT || state_ff == S_RSCAN)
                    && (cnt_ff < occ_ff);
   assign mem_ra  = cnt_ff[IDX_W-1:0];

   assign take_min = !sel_ok_ff || (d_hits < sel_val_ff);
   assign take_asc = (!have_prev_ff || (d_id > prev_id_ff))
                     && (!sel_ok_ff || (d_id < sel_id_ff));

   always_comb begin
      if (fsize_ff == '0) begin
         eff_size = CW'(1);
      end else if (CW'(fsize_ff) > CW'(SLOTS)) begin
         eff_size = CW'(SLOTS);
      end else begin
         eff_size = CW'(fsize_ff);
      end
   end
   assign frame_full = CW'(occ_ff) >= eff_size;

   assign hit_sat  = (hit_val_ff == COUNT_MAX) ? hit_val_ff : hit_val_ff + COUNT_ONE;
   assign cand_ext = {{ID_BITS{1'b0}}, req_chan.candidate};
   assign id_ext   = {{ENTRY_W{1'b0}}, res_id_ff};
   assign ev_ext   = {{ENTRY_W{1'b0}}, res_ev_ff};
   assign hits_ext = {{HITS_W{1'b0}}, res_hits_ff};

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_FRAME_SIZE) ? APB_W'(fsize_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      fsize_in     = fsize_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = issue;
      rd_idx_in    = cnt_ff;
      cand_in      = cand_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_val_in   = hit_val_ff;
      sel_ok_in    = sel_ok_ff;
      sel_idx_in   = sel_idx_ff;
      sel_id_in    = sel_id_ff;
      sel_val_in   = sel_val_ff;
      have_prev_in = have_prev_ff;
      prev_id_in   = prev_id_ff;
      emit_cnt_in  = emit_cnt_ff;
      res_kind_in  = res_kind_ff;
      res_id_in    = res_id_ff;
      res_hits_in  = res_hits_ff;
      res_ev_in    = res_ev_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;

      if (csr_wr && paddr[2] == REG_FRAME_SIZE) begin
         fsize_in = pwdata[FSIZE_W-1:0];
      end

      if (issue) begin
         cnt_in = cnt_ff + OCC_ONE;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cand_in   = cand_ext[ID_BITS-1:0];
               cnt_in    = '0;
               hit_in    = 1'b0;
               sel_ok_in = 1'b0;
               if (req_chan.mode == MODE_RECOMMEND) begin
                  state_in = (occ_ff == '0) ? S_DECIDE : S_SCAN;
               end else if (occ_ff == '0) begin
                  res_kind_in = KIND_RD_EMPTY;
                  res_id_in   = '0;
                  res_hits_in = '0;
                  res_ev_in   = '0;
                  res_last_in = 1'b1;
                  state_in    = S_PUT;
               end else begin
                  have_prev_in = 1'b0;
                  emit_cnt_in  = '0;
                  state_in     = S_RSCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (d_id == cand_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_val_in = d_hits;
               end
               if (take_min) begin
                  sel_ok_in  = 1'b1;
                  sel_idx_in = rd_idx_ff;
                  sel_id_in  = d_id;
                  sel_val_in = d_hits;
               end
            end
            if (last_rd) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_id_in   = cand_ff;
            res_last_in = 1'b1;
            res_ev_in   = '0;
            if (hit_ff) begin
               mem_we      = 1'b1;
               mem_wa      = hit_idx_ff[IDX_W-1:0];
               mem_wd      = {cand_ff, hit_sat};
               res_kind_in = KIND_HIT;
               res_hits_in = hit_sat;
               state_in    = S_PUT;
            end else if (frame_full) begin
               res_ev_in   = sel_id_ff;
               res_kind_in = KIND_INS_EVICT;
               res_hits_in = COUNT_ONE;
               if (sel_idx_ff == occ_m1) begin
                  state_in = S_APPEND;
               end else begin
                  cnt_in   = sel_idx_ff + OCC_ONE;
                  state_in = S_SHIFT;
               end
            end else begin
               mem_we      = 1'b1;
               mem_wa      = occ_ff[IDX_W-1:0];
               mem_wd      = {cand_ff, COUNT_ONE};
               occ_in      = occ_ff + OCC_ONE;
               res_kind_in = KIND_INS_FREE;
               res_hits_in = COUNT_ONE;
               state_in    = S_PUT;
            end
         end
         S_SHIFT: begin
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = IDX_W'(rd_idx_ff - OCC_ONE);
               mem_wd = rd_data_ff;
            end
            if (last_rd) begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            mem_we   = 1'b1;
            mem_wa   = occ_m1[IDX_W-1:0];
            mem_wd   = {cand_ff, COUNT_ONE};
            state_in = S_PUT;
         end
         S_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_id_in    = id_ext[ENTRY_W-1:0];
               rsp_hits_in  = hits_ext[HITS_W-1:0];
               rsp_ev_in    = ev_ext[ENTRY_W-1:0];
               rsp_last_in  = res_last_ff;
               if (res_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in       = '0;
                  sel_ok_in    = 1'b0;
                  have_prev_in = 1'b1;
                  prev_id_in   = res_id_ff;
                  emit_cnt_in  = emit_cnt_ff + OCC_ONE;
                  state_in     = S_RSCAN;
               end
            end
         end
         S_RSCAN: begin
            if (rd_vld_ff && take_asc) begin
               sel_ok_in  = 1'b1;
               sel_id_in  = d_id;
               sel_val_in = d_hits;
            end
            if (last_rd) begin
               res_kind_in = KIND_RD_ENTRY;
               res_id_in   = take_asc ? d_id : sel_id_ff;
               res_hits_in = take_asc ? d_hits : sel_val_ff;
               res_ev_in   = '0;
               res_last_in = (emit_cnt_ff == occ_m1);
               state_in    = S_PUT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         fsize_ff     <= FSIZE_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         fsize_ff     <= fsize_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rd_idx_ff    <= rd_idx_in;
      cand_ff      <= cand_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_val_ff   <= hit_val_in;
      sel_ok_ff    <= sel_ok_in;
      sel_idx_ff   <= sel_idx_in;
      sel_id_ff    <= sel_id_in;
      sel_val_ff   <= sel_val_in;
      have_prev_ff <= have_prev_in;
      prev_id_ff   <= prev_id_in;
      emit_cnt_ff  <= emit_cnt_in;
      res_kind_ff  <= res_kind_in;
      res_id_ff    <= res_id_in;
      res_hits_ff  <= res_hits_in;
      res_ev_ff    <= res_ev_in;
      res_last_ff  <= res_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_hits_ff  <= rsp_hits_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.entry_id   = rsp_id_ff;
   assign rsp_chan.hit_count  = rsp_hits_ff;
   assign rsp_chan.evicted_id = rsp_ev_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule
